FILE: design/lie_pkg.sv
// Package for the Lagrange interpolation evaluator.
// Holds the command and status codes and the status struct of the multiply/divide unit.
// No dependencies.
package lie_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DUP = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  localparam int CFG_WIDTH = 5;
  localparam int IDX_WIDTH = 4;

  typedef struct packed {
    logic done;
    logic ovf;
  } md_stat_t;

endpackage

FILE: design/lie_node_mem.sv
// Node store: x and y words, one write port and two registered read ports.
// Depends on nothing but its parameters.
module lie_node_mem #(
  parameter int MAX_NODES  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_NODES)-1:0]  waddr,
  input  logic [WORD_WIDTH-1:0]         wx,
  input  logic [WORD_WIDTH-1:0]         wy,
  input  logic [$clog2(MAX_NODES)-1:0]  raddr_a,
  input  logic [$clog2(MAX_NODES)-1:0]  raddr_b,
  output logic [WORD_WIDTH-1:0]         x_a_r,
  output logic [WORD_WIDTH-1:0]         y_a_r,
  output logic [WORD_WIDTH-1:0]         x_b_r
);

  logic [WORD_WIDTH-1:0] x_mem [MAX_NODES];
  logic [WORD_WIDTH-1:0] y_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[waddr] <= wx;
      y_mem[waddr] <= wy;
    end
    x_a_r <= x_mem[raddr_a];
    y_a_r <= y_mem[raddr_a];
    x_b_r <= x_mem[raddr_b];
  end

endmodule

FILE: design/lie_muldiv.sv
// Shared shift-add multiplier and restoring divider built around one adder.
// Computes (mag * nmag) / dmag truncated, flags quotients above WORD_WIDTH+1 bits.
// Depends on lie_pkg.
module lie_muldiv #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [WORD_WIDTH-1:0]  mag,
  input  logic [WORD_WIDTH:0]    nmag,
  input  logic [WORD_WIDTH:0]    dmag,
  output logic [WORD_WIDTH:0]    quo_r,
  output lie_pkg::md_stat_t      stat
);

  localparam int W   = WORD_WIDTH;
  localparam int PW  = 2 * W + 1;
  localparam int AW  = 2 * W + 2;
  localparam int NW  = $clog2(PW + 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MUL  = 3'b010,
    PH_DIV  = 3'b100
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [W:0]      mpl_r, mpl_nxt;
  logic [W:0]      div_r;
  logic [W+1:0]    rem_r, rem_nxt;
  logic [W:0]      quo_nxt;
  logic            ovf_r, ovf_nxt;
  logic            done_r, done_nxt;
  logic [W-1:0]    mag_r;
  logic [W+1:0]    rsh;
  logic [AW-1:0]   op_a, op_b, sum;
  logic            cin;

  assign rsh = {rem_r[W:0], acc_r[PW-1]};

  // One adder serves both the multiply steps and the trial subtractions.
  always_comb begin
    op_a = '0;
    op_b = '0;
    cin  = 1'b0;
    if (phase_r == PH_DIV) begin
      op_a = AW'(rsh);
      op_b = ~AW'(div_r);
      cin  = 1'b1;
    end else begin
      op_a = AW'({acc_r[PW-2:0], 1'b0});
      op_b = mpl_r[W] ? AW'(mag_r) : '0;
    end
  end

  assign sum = op_a + op_b + AW'(cin);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mpl_nxt   = mpl_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_MUL;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          mpl_nxt   = nmag;
        end
      end
      PH_MUL: begin
        acc_nxt = sum[PW-1:0];
        mpl_nxt = {mpl_r[W-1:0], 1'b0};
        if (cnt_r == NW'(W)) begin
          phase_nxt = PH_DIV;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          ovf_nxt   = 1'b0;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      PH_DIV: begin
        acc_nxt = {acc_r[PW-2:0], 1'b0};
        ovf_nxt = ovf_r | quo_r[W];
        if (sum[AW-1]) begin
          rem_nxt = rsh;
          quo_nxt = {quo_r[W-1:0], 1'b0};
        end else begin
          rem_nxt = sum[W+1:0];
          quo_nxt = {quo_r[W-1:0], 1'b1};
        end
        if (cnt_r == NW'(PW - 1)) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    mpl_r <= mpl_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
    if (phase_r == PH_IDLE && start) begin
      mag_r <= mag;
      div_r <= dmag;
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

FILE: design/lagrange_interpolation_eval.sv
// Lagrange interpolation evaluator, top level: node store, sequencer, running sum.
// Depends on lie_pkg, lie_node_mem and lie_muldiv.
//
// Usage:
//   The input channel (in_valid/in_ready) carries write and evaluate transactions.
//   A write (in_cmd = write) stores node_x/node_y at in_node_index; it produces no
//   result. An evaluate transaction produces one result on the out_ and
//   channel: the signed fixed-point interpolated value and a status code
//   (ok, duplicate nodes, saturated).
//   cfg_we/cfg_wdata set the node count; write it only while the block is idle.
//   An evaluate with n nodes first scans each node pair for duplicate x values,
//   then runs each term through its sequencer steps and n-1 factors, each factor
//   one pass through the shared multiply/divide unit with its start and check
//   steps. A term that reaches zero skips its remaining factors, and duplicate
//   nodes end the scan early.
//   in_ready is low while an evaluation runs. A finished result waits in the
//   output register while the receiver stalls; the next transaction is taken
//   meanwhile, and a second evaluation waits at its end until the first result
//   leaves. Reset clears the control state and sets the node count to 1; the node
//   store is not cleared and must be written before use.
module lagrange_interpolation_eval #(
  parameter int MAX_NODES  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic [lie_pkg::IDX_WIDTH-1:0]         in_node_index,
  input  logic signed [WORD_WIDTH-1:0]          in_node_x,
  input  logic signed [WORD_WIDTH-1:0]          in_node_y,
  input  logic signed [WORD_WIDTH-1:0]          in_query_x,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [WORD_WIDTH-1:0]          out_interp_value,
  output logic [1:0]                            out_status,
  input  logic                                  cfg_we,
  input  logic [lie_pkg::CFG_WIDTH-1:0]         cfg_wdata
);

  localparam int W  = WORD_WIDTH;
  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DUP_RD  = 10'b0000000010,
    ST_DUP_CMP = 10'b0000000100,
    ST_TERM_RD = 10'b0000001000,
    ST_TERM_LD = 10'b0000010000,
    ST_FAC_CHK = 10'b0000100000,
    ST_FAC_GO  = 10'b0001000000,
    ST_FAC_WT  = 10'b0010000000,
    ST_ACC     = 10'b0100000000,
    ST_FIN     = 10'b1000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [lie_pkg::CFG_WIDTH-1:0] node_count_r;
  logic [CW-1:0]            n_r, n_nxt, n_eff;
  logic [CW-1:0]            j_r, j_nxt, k_r, k_nxt;
  logic [W-1:0]             q_r, q_nxt;
  logic [W-1:0]             xj_r, xj_nxt;
  logic [W-1:0]             mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [W-1:0]             sum_r, sum_nxt;
  logic                     sat_r, sat_nxt;
  logic                     dup_r, dup_nxt;
  logic                     out_valid_r;
  logic [W-1:0]             out_value_r;
  logic [1:0]               out_status_r;

  logic                     accept, mem_we;
  logic [IW-1:0]            raddr_a, raddr_b;
  logic [W-1:0]             x_a, y_a, x_b;
  logic [W:0]               dq, dd, nmag, dmag, limit;
  logic                     neg_fac;
  logic                     md_start;
  logic [W:0]               md_quo;
  lie_pkg::md_stat_t        md_stat;
  logic [W:0]               term;
  logic [W+1:0]             acc_sum;
  logic                     acc_ovf;
  logic [W-1:0]             acc_clamp;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign mem_we   = accept && (in_cmd == lie_pkg::CMD_WRITE)
                    && (int'(in_node_index) < MAX_NODES);

  // Node count of zero means one node; counts above the store depth are clamped.
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count_r);
    end
  end

  always_comb begin
    raddr_a = j_r[IW-1:0];
    raddr_b = k_r[IW-1:0];
  end

  lie_node_mem #(
    .MAX_NODES  (MAX_NODES),
    .WORD_WIDTH (W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (IW'(in_node_index)),
    .wx      (in_node_x),
    .wy      (in_node_y),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .x_a_r   (x_a),
    .y_a_r   (y_a),
    .x_b_r   (x_b)
  );

  // Exact differences, split into sign and magnitude.
  always_comb begin
    dq      = {q_r[W-1], q_r} - {x_b[W-1], x_b};
    dd      = {xj_r[W-1], xj_r} - {x_b[W-1], x_b};
    nmag    = dq[W] ? (~dq + (W+1)'(1)) : dq;
    dmag    = dd[W] ? (~dd + (W+1)'(1)) : dd;
    neg_fac = neg_r ^ dq[W] ^ dd[W];
  end

  assign md_start = (state_r == ST_FAC_GO);

  lie_muldiv #(
    .WORD_WIDTH (W)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .mag   (mag_r),
    .nmag  (nmag),
    .dmag  (dmag),
    .quo_r (md_quo),
    .stat  (md_stat)
  );

  assign limit = neg_r ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - (W+1)'(1));

  // Saturating accumulation of one signed term.
  always_comb begin
    term      = neg_r ? (~{1'b0, mag_r} + (W+1)'(1)) : {1'b0, mag_r};
    acc_sum   = {{2{sum_r[W-1]}}, sum_r} + {term[W], term};
    acc_ovf   = (acc_sum[W+1:W-1] != 3'b000) && (acc_sum[W+1:W-1] != 3'b111);
    acc_clamp = acc_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    q_nxt     = q_r;
    xj_nxt    = xj_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    sum_nxt   = sum_r;
    sat_nxt   = sat_r;
    dup_nxt   = dup_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == lie_pkg::CMD_EVAL) begin
          q_nxt   = in_query_x;
          n_nxt   = n_eff;
          j_nxt   = '0;
          k_nxt   = CW'(1);
          sum_nxt = '0;
          sat_nxt = 1'b0;
          dup_nxt = 1'b0;
          state_nxt = (n_eff == CW'(1)) ? ST_TERM_RD : ST_DUP_RD;
        end
      end
      ST_DUP_RD: state_nxt = ST_DUP_CMP;
      ST_DUP_CMP: begin
        if (x_a == x_b) begin
          dup_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if ((CW+1)'(k_r) + (CW+1)'(1) == (CW+1)'(n_r)) begin
          if ((CW+1)'(j_r) + (CW+1)'(2) == (CW+1)'(n_r)) begin
            j_nxt     = '0;
            state_nxt = ST_TERM_RD;
          end else begin
            j_nxt     = j_r + CW'(1);
            k_nxt     = j_r + CW'(2);
            state_nxt = ST_DUP_RD;
          end
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_DUP_RD;
        end
      end
      ST_TERM_RD: state_nxt = ST_TERM_LD;
      ST_TERM_LD: begin
        xj_nxt    = x_a;
        neg_nxt   = y_a[W-1];
        mag_nxt   = y_a[W-1] ? (~y_a + W'(1)) : y_a;
        k_nxt     = '0;
        state_nxt = ST_FAC_CHK;
      end
      ST_FAC_CHK: begin
        if (mag_r == '0 || k_r == n_r) begin
          state_nxt = ST_ACC;
        end else if (k_r == j_r) begin
          k_nxt = k_r + CW'(1);
        end else begin
          state_nxt = ST_FAC_GO;
        end
      end
      ST_FAC_GO: begin
        neg_nxt   = neg_fac;
        state_nxt = ST_FAC_WT;
      end
      ST_FAC_WT: begin
        if (md_stat.done) begin
          if (md_stat.ovf || md_quo > limit) begin
            mag_nxt = limit[W-1:0];
            sat_nxt = 1'b1;
          end else begin
            mag_nxt = md_quo[W-1:0];
          end
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_FAC_CHK;
        end
      end
      ST_ACC: begin
        if (acc_ovf) begin
          sum_nxt = acc_clamp;
          sat_nxt = 1'b1;
        end else begin
          sum_nxt = acc_sum[W-1:0];
        end
        if ((CW+1)'(j_r) + (CW+1)'(1) == (CW+1)'(n_r)) begin
          state_nxt = ST_FIN;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_TERM_RD;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= lie_pkg::CFG_WIDTH'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (state_r == ST_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    n_r   <= n_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    q_r   <= q_nxt;
    xj_r  <= xj_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    sum_r <= sum_nxt;
    sat_r <= sat_nxt;
    dup_r <= dup_nxt;
    if (state_r == ST_FIN && (!out_valid_r || out_ready)) begin
      if (dup_r) begin
        out_value_r  <= '0;
        out_status_r <= lie_pkg::STAT_DUP;
      end else begin
        out_value_r  <= sum_r;
        out_status_r <= sat_r ? lie_pkg::STAT_SAT : lie_pkg::STAT_OK;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

FILE: design/lie_checker.sv
// Port-level checks for the Lagrange interpolation evaluator, with its bind.
// Depends on lie_pkg and lagrange_interpolation_eval.
module lie_checker #(
  parameter int WORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_cmd,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [WORD_WIDTH-1:0]  out_interp_value,
  input logic [1:0]             out_status
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interp_value)
      && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == lie_pkg::STAT_OK || out_status == lie_pkg::STAT_DUP
      || out_status == lie_pkg::STAT_SAT))
    else $error("undefined status code");

  a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == lie_pkg::STAT_DUP |-> out_interp_value == '0)
    else $error("duplicate-node result is not zero");

  // An accepted evaluation makes the block busy, so in_ready falls after it is taken.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == lie_pkg::CMD_EVAL |=> !in_ready)
    else $error("input taken during an evaluation");

endmodule

bind lagrange_interpolation_eval lie_checker #(
  .WORD_WIDTH (WORD_WIDTH)
) u_lie_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_cmd           (in_cmd),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_interp_value (out_interp_value),
  .out_status       (out_status)
);
